// ===== rtl/core/fsq_pkg.sv =====
// Shared types and constants for the FCFS/SJF task queue.
// No dependencies; imported by every module of the block.
package fsq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ID_W            = 16;
    localparam int DUR_W           = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_GRAB   = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_LOOKUP = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_IGNORED  = 3'd4
    } status_t;

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_SJF  = 2'd1;

    localparam logic [2:0] ADDR_ORDER_MODE = 3'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [DUR_W-1:0] dur;
    } entry_t;

    typedef struct packed {
        status_t          status;
        logic [ID_W-1:0]  id;
        logic [DUR_W-1:0] dur;
    } result_t;

endpackage

// ===== rtl/core/fsq_entry_ram.sv =====
// Entry store: one write port, one read port, registered read data.
// Depends on fsq_pkg for entry_t.
module fsq_entry_ram
    import fsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int AW          = $clog2(QUEUE_DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [QUEUE_DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/fsq_ctrl.sv =====
// Request sequencer: walks the entry store slot by slot, inserting with a
// forward ripple or deleting with a backward shift. Depends on fsq_pkg.
module fsq_ctrl
    import fsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int AW          = $clog2(QUEUE_DEPTH),
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req_type,
    input  logic [ID_W-1:0]  req_id,
    input  logic [DUR_W-1:0] req_dur,
    input  logic [1:0]       order_mode,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res,
    output logic             mem_we,
    output logic [AW-1:0]    mem_waddr,
    output entry_t           mem_wdata,
    output logic [AW-1:0]    mem_raddr,
    input  entry_t           mem_rdata
);

    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    state_t           state_reg,  state_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic [CW-1:0]    idx_reg,    idx_next;
    logic             found_reg,  found_next;
    req_t             op_reg,     op_next;
    logic [ID_W-1:0]  id_reg,     id_next;
    logic [DUR_W-1:0] dur_reg,    dur_next;
    entry_t           carry_reg,  carry_next;
    result_t          res_reg,    res_next;

    logic             last;
    logic             hit;
    logic [CW-1:0]    idx_inc;
    logic [CW-1:0]    idx_dec;
    entry_t           new_entry;

    assign idx_inc   = idx_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;
    assign last      = (idx_reg == count_reg);
    assign new_entry = '{id: id_reg, dur: dur_reg};

    always_comb
    begin
        hit = 1'b0;
        case (op_reg)
            REQ_INSERT:
                hit = (idx_reg == '0) ? (mem_rdata.dur > dur_reg)
                                      : (mem_rdata.dur >= dur_reg);
            REQ_GRAB:
                hit = 1'b1;
            REQ_REMOVE, REQ_LOOKUP:
                hit = (mem_rdata.id == id_reg);
            default:
                hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        id_reg    <= id_next;
        dur_reg   <= dur_next;
        carry_reg <= carry_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        op_next    = op_reg;
        id_next    = id_reg;
        dur_next   = dur_reg;
        carry_next = carry_reg;
        res_next   = res_reg;
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[AW-1:0];
        mem_wdata  = new_entry;
        mem_raddr  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next    = req_type;
                    id_next    = req_id;
                    dur_next   = req_dur;
                    idx_next   = '0;
                    found_next = 1'b0;
                    res_next   = '{status: STAT_OK, id: '0, dur: '0};
                    if (req_type == REQ_INSERT)
                    begin
                        if (order_mode != MODE_FCFS && order_mode != MODE_SJF)
                        begin
                            res_next.status = STAT_IGNORED;
                            state_next      = ST_RESP;
                        end
                        else if (count_reg == DEPTH_C)
                        begin
                            res_next.status = STAT_FULL;
                            state_next      = ST_RESP;
                        end
                        else if (order_mode == MODE_FCFS || count_reg == '0)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            mem_wdata  = '{id: req_id, dur: req_dur};
                            count_next = count_reg + 1'b1;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.status = STAT_EMPTY;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                mem_raddr = idx_inc[AW-1:0];
                idx_next  = idx_inc;
                if (op_reg == REQ_INSERT)
                begin
                    if (last)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = idx_reg[AW-1:0];
                        mem_wdata  = found_reg ? carry_reg : new_entry;
                        count_next = count_reg + 1'b1;
                        state_next = ST_RESP;
                    end
                    else if (found_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = idx_reg[AW-1:0];
                        mem_wdata  = carry_reg;
                        carry_next = mem_rdata;
                    end
                    else if (hit)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = idx_reg[AW-1:0];
                        mem_wdata  = new_entry;
                        carry_next = mem_rdata;
                        found_next = 1'b1;
                    end
                end
                else
                begin
                    if (last)
                    begin
                        if (found_reg)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        else
                        begin
                            res_next.status = STAT_NOTFOUND;
                        end
                        state_next = ST_RESP;
                    end
                    else if (found_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_dec[AW-1:0];
                        mem_wdata = mem_rdata;
                    end
                    else if (hit)
                    begin
                        found_next = 1'b1;
                        if (op_reg != REQ_REMOVE)
                        begin
                            res_next.id  = mem_rdata.id;
                            res_next.dur = mem_rdata.dur;
                        end
                        if (op_reg == REQ_LOOKUP)
                        begin
                            state_next = ST_RESP;
                        end
                    end
                end
            end

            ST_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

// ===== rtl/core/fcfs_sjf_task_queue_core.sv =====
// Top level of the FCFS/SJF task queue: APB register, stream ports, output stage.
// Depends on fsq_pkg, fsq_entry_ram and fsq_ctrl.
//
// One request word in, one result word out. An ignored, full or empty
// request, a first-come-first-served insert and any insert into an empty
// queue go straight from accept to the result. Shortest-job-first insert into
// a non-empty queue, grab and remove walk all stored entries one slot per
// cycle; a look up stops at its match. The walk is set by the entry
// store having a single read and a single write port. A new request is
// taken while a finished result still waits at the output register.
// The entry store needs no clearing after reset.
module fcfs_sjf_task_queue_core
    import fsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // task_id[15:0], duration[47:16]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // task_id_res[15:0], duration_res[47:16]
    output logic [2:0]  m_tuser,   // status[2:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [1:0]  order_mode_reg;
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    logic        res_valid;
    logic        res_ready;
    result_t     res;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    entry_t      mem_wdata;
    entry_t      mem_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_ORDER_MODE[2]) ? {30'b0, order_mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg <= MODE_FCFS;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == ADDR_ORDER_MODE[2])
        begin
            order_mode_reg <= pwdata[1:0];
        end
    end

    fsq_entry_ram #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fsq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_type   (req_t'(s_tuser)),
        .req_id     (s_tdata[15:0]),
        .req_dur    (s_tdata[47:16]),
        .order_mode (order_mode_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_tdata_reg <= {res.dur, res.id};
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for fcfs_sjf_task_queue_core: directed and random requests checked against a
// shadow copy of the task queue. Depends on fsq_pkg and the core RTL; reads no files.
module tb;
    import fsq_pkg::*;

    localparam int DEPTH     = 64;
    localparam int CYCLE_CAP = 400000;
    localparam int PHASE_LEN = 75;
    localparam int PHASES    = 12;

    localparam logic [1:0] MODE_IGNORE = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    class queue_shadow;
        int               errors;
        int               depth;
        logic [1:0]       mode;
        logic [ID_W-1:0]  ids[$];
        logic [DUR_W-1:0] durs[$];
        result_t          due_results[$];

        function new(int n);
            depth  = n;
            errors = 0;
            mode   = MODE_FCFS;
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH @%0t: %s", $time, what);
        endtask

        function void take_word(req_t req, logic [ID_W-1:0] id, logic [DUR_W-1:0] dur);
            result_t r;
            int      pos;
            r.status = STAT_OK;
            r.id     = '0;
            r.dur    = '0;
            pos      = -1;
            if (req == REQ_INSERT)
            begin
                if (mode != MODE_FCFS && mode != MODE_SJF)
                    r.status = STAT_IGNORED;
                else if (ids.size() >= depth)
                    r.status = STAT_FULL;
                else
                begin
                    pos = ids.size();
                    if (mode == MODE_SJF)
                    begin
                        // head wins only if strictly longer; later slots on >=
                        if (ids.size() == 0 || durs[0] > dur)
                            pos = 0;
                        else
                            for (int i = 1; i < ids.size() && pos == ids.size(); i++)
                                if (durs[i] >= dur)
                                    pos = i;
                    end
                    ids.insert(pos, id);
                    durs.insert(pos, dur);
                end
            end
            else if (ids.size() == 0)
                r.status = STAT_EMPTY;
            else if (req == REQ_GRAB)
            begin
                r.id  = ids.pop_front();
                r.dur = durs.pop_front();
            end
            else
            begin
                foreach (ids[i])
                    if (pos < 0 && ids[i] == id)
                        pos = i;
                if (pos < 0)
                    r.status = STAT_NOTFOUND;
                else if (req == REQ_REMOVE)
                begin
                    ids.delete(pos);
                    durs.delete(pos);
                end
                else
                begin
                    r.id  = ids[pos];
                    r.dur = durs[pos];
                end
            end
            due_results.push_back(r);
        endfunction

        task match_result(status_t st, logic [ID_W-1:0] id, logic [DUR_W-1:0] dur);
            result_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("unexpected word status=%0d id=%h dur=%h", st, id, dur));
                return;
            end
            want = due_results.pop_front();
            if (st != want.status)
                report($sformatf("status %0d, want %0d", st, want.status));
            if (id != want.id)
                report($sformatf("task_id_res %h, want %h", id, want.id));
            if (dur != want.dur)
                report($sformatf("duration_res %h, want %h", dur, want.dur));
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;     // task_id[15:0], duration[47:16]
    logic [1:0]  s_tuser  = REQ_INSERT; // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // task_id_res[15:0], duration_res[47:16]
    logic [2:0]  m_tuser;           // status[2:0]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    queue_shadow shadow = new(DEPTH);

    int gap_pct    = 0;
    int stall_pct  = 0;
    int stall_left = 0;
    int cycles     = 0;
    bit calm       = 1'b0;

    fcfs_sjf_task_queue_core #(.QUEUE_DEPTH(DEPTH)) DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        if (stall_left > 0 && !calm)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(1, 10) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            shadow.match_result(status_t'(m_tuser), m_tdata[ID_W-1:0], m_tdata[ID_W +: DUR_W]);

    task automatic send_word(req_t req, logic [ID_W-1:0] id, logic [DUR_W-1:0] dur);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dur, id};
        s_tuser  <= req;
        do @(posedge clk); while (!s_tready);
        shadow.take_word(req, id, dur);
    endtask

    task automatic idle_until_drained();
        s_tvalid <= 1'b0;
        while (shadow.due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(logic [1:0] mode);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ORDER_MODE;
        pwdata  <= {30'b0, mode};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        shadow.mode = mode;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {30'b0, mode})
            shadow.report($sformatf("order_mode reads %h, want %0d", prdata, mode));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_word(int ins_pct);
        req_t             req;
        logic [ID_W-1:0]  id;
        logic [DUR_W-1:0] dur;
        int               pick;
        if ($urandom_range(0, 99) < ins_pct)
            req = REQ_INSERT;
        else
            req = req_t'($urandom_range(1, 3));
        // non-insert ids mostly hit stored entries; a small pool makes duplicates
        if (req != REQ_INSERT && shadow.ids.size() != 0 && $urandom_range(0, 99) < 70)
            id = shadow.ids[$urandom_range(0, shadow.ids.size() - 1)];
        else if ($urandom_range(0, 2) == 0)
            id = ID_W'($urandom_range(0, 7));
        else
            id = ID_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 2)
            dur = DUR_W'($urandom_range(0, 7));
        else if (pick < 3)
            dur = ($urandom_range(0, 1) == 1) ? '1 : '0;
        else if (pick < 5 && shadow.durs.size() != 0)
            dur = shadow.durs[$urandom_range(0, shadow.durs.size() - 1)];
        else
            dur = DUR_W'($urandom);
        send_word(req, id, dur);
    endtask

    initial
    begin
        logic [1:0] mode_seq [PHASES] = '{MODE_FCFS, MODE_IGNORE, MODE_SJF, MODE_SJF,
                                          MODE_FCFS, MODE_SPARE, MODE_SJF, MODE_FCFS,
                                          MODE_SJF, MODE_IGNORE, MODE_SJF, MODE_FCFS};
        int         ins_seq  [PHASES] = '{95, 50, 30, 85, 40, 60, 70, 50, 20, 40, 90, 55};
        int         pct_pool [3]      = '{0, 15, 40};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // first come first served, empty and missing cases
        send_word(REQ_GRAB,   16'h0000, 32'h0000_0000);
        send_word(REQ_REMOVE, 16'h0005, 32'hFFFF_FFFF);
        send_word(REQ_LOOKUP, 16'h0005, 32'h0000_0000);
        send_word(REQ_INSERT, 16'h0000, 32'h0000_0000);
        send_word(REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(REQ_INSERT, 16'h5A5A, 32'hA5A5_A5A5);
        send_word(REQ_LOOKUP, 16'hFFFF, 32'h0000_0000);
        send_word(REQ_LOOKUP, 16'h1234, 32'h0000_0000);
        send_word(REQ_REMOVE, 16'h1234, 32'h0000_0000);
        send_word(REQ_REMOVE, 16'h0000, 32'h0000_0000);
        send_word(REQ_GRAB,   16'h0000, 32'h0000_0000);
        send_word(REQ_GRAB,   16'h0000, 32'h0000_0000);
        send_word(REQ_GRAB,   16'h0000, 32'h0000_0000);

        // shortest job first: ties behind head, new head, ties in the body, dup ids
        idle_until_drained();
        write_mode(MODE_SJF);
        send_word(REQ_INSERT, 16'h0001, 32'd100);
        send_word(REQ_INSERT, 16'h0002, 32'd100);
        send_word(REQ_INSERT, 16'h0003, 32'd50);
        send_word(REQ_INSERT, 16'h0004, 32'd100);
        send_word(REQ_INSERT, 16'h0005, 32'h0000_0000);
        send_word(REQ_INSERT, 16'h0006, 32'hFFFF_FFFF);
        send_word(REQ_INSERT, 16'h0001, 32'd20);
        send_word(REQ_LOOKUP, 16'h0001, 32'h0000_0000);

        idle_until_drained();
        write_mode(MODE_IGNORE);
        send_word(REQ_INSERT, 16'h0007, 32'd7);
        send_word(REQ_GRAB,   16'h0000, 32'h0000_0000);
        idle_until_drained();
        write_mode(MODE_SPARE);
        send_word(REQ_INSERT, 16'h0008, 32'd8);

        for (int p = 0; p < PHASES; p++)
        begin
            idle_until_drained();
            write_mode(mode_seq[p]);
            calm      = (p == PHASES - 1);
            gap_pct   = pct_pool[$urandom_range(0, 2)];
            stall_pct = pct_pool[$urandom_range(0, 2)];
            repeat (PHASE_LEN)
                random_word(ins_seq[p]);
        end

        idle_until_drained();
        repeat (100) @(posedge clk);
        if (shadow.due_results.size() != 0)
            shadow.report($sformatf("%0d results never arrived", shadow.due_results.size()));
        if (shadow.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
